// File: hw/rtl/sorted_list_table_core_defines.svh
// Assertion macros for the sorted list table core.
`ifndef SORTED_LIST_TABLE_CORE_DEFINES_SVH
`define SORTED_LIST_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLT_ASSERT(label, clk, rst, prop, msg)
`define SLT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/slt_pkg.sv
// Shared types and constants for the sorted list table core.
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Step strobes from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } dp_cmd_t;

endpackage

// File: hw/rtl/sorted_list_table_core.sv
// Top level of the sorted list table core: controller plus datapath.
//
//  channel  | transfer when       | signals
//  ---------+---------------------+--------------------------------
//  command  | start && !busy      | cmd, key_value
//  result   | done (one cycle)    | status, position, entry_count
//
// Each command runs capture, one compare of the key against
// all sixteen entries in parallel, then a commit that shifts the entry row
// and registers the result; done is raised in the cycle after the commit.
// A new command may be taken in the cycle that done is high.
// Reset clears the entry count and the controller; entry contents stay as is.
// The receiver cannot stall: the result is shown for one cycle only.
`include "sorted_list_table_core_defines.svh"
module sorted_list_table_core
  import slt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    done,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        position,
  output logic [CNT_W-1:0]        entry_count
);

  dp_cmd_t dp_cmd;

  slt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .dp_cmd (dp_cmd)
  );

  slt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .cmd         (cmd),
    .key_value   (key_value),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  // Check latency, exclusivity of result and busy, count bounds and full status
  `SLT_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##3 done, "result latency broken")
  `SLT_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result while busy")
  `SLT_ASSERT_ALWAYS(a_count_max, clk, rst || (entry_count <= CNT_W'(CAPACITY)),
    "count over capacity")
  `SLT_ASSERT(a_full_count, clk, rst,
    (done && status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)),
    "full status below capacity")

endmodule

// File: hw/rtl/slt_ctrl.sv
// Controller state machine for the sorted list table core.
module slt_ctrl
  import slt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPARE = 3'b010,
    S_COMMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Walk idle -> compare -> commit per transfer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_COMPARE;
      S_COMPARE: state_next = S_COMMIT;
      S_COMMIT:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive datapath step strobes
  assign busy           = (state != S_IDLE);
  assign dp_cmd.capture = (state == S_IDLE) && start;
  assign dp_cmd.compare = (state == S_COMPARE);
  assign dp_cmd.commit  = (state == S_COMMIT);

endmodule

// File: hw/rtl/slt_datapath.sv
// Entry row with parallel compare cells, shift network and result registers.
module slt_datapath
  import slt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 dp_cmd,
  input  logic [1:0]              cmd,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    done,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        position,
  output logic [CNT_W-1:0]        entry_count
);

  logic [1:0]              cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] entries      [CAPACITY];
  logic signed [KEY_W-1:0] entries_next [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CAPACITY-1:0]     lt_mask;
  logic [CAPACITY-1:0]     eq_mask;
  logic [CAPACITY-1:0]     seen;
  logic [IDX_W-1:0]        first_eq;
  logic                    any_eq;
  logic                    full;
  status_t                 status_next;
  logic [IDX_W-1:0]        position_next;
  logic                    done_q;

  // Hold the command for the item in flight
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q <= cmd;
      key_q <= key_value;
    end
  end

  // Compare every live entry against the key; lt_mask is a prefix of the row
  always_ff @(posedge clk) begin
    if (dp_cmd.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        lt_mask[i] <= (CNT_W'(i) < count) && (entries[i] < key_q);
        eq_mask[i] <= (CNT_W'(i) < count) && (entries[i] == key_q);
      end
    end
  end

  // Locate the first equal entry and mark it and everything above it
  always_comb begin
    first_eq = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq_mask[i]) first_eq = IDX_W'(i);
    end
    seen[0] = eq_mask[0];
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i] = seen[i-1] | eq_mask[i];
    end
  end

  assign any_eq = |eq_mask;
  assign full   = (count == CNT_W'(CAPACITY));

  // Build the next row, count and result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entries_next[i] = entries[i];
    count_next    = count;
    status_next   = ST_OK;
    position_next = '0;
    case (cmd_t'(cmd_q))
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          // Keep smaller entries, drop the key at the boundary, shift the rest up
          if (!lt_mask[0]) entries_next[0] = key_q;
          for (int i = 1; i < CAPACITY; i++) begin
            if (!lt_mask[i]) entries_next[i] = lt_mask[i-1] ? key_q : entries[i-1];
          end
          count_next = count + CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (any_eq) position_next = first_eq;
        else        status_next   = ST_MISS;
      end
      CMD_REMOVE: begin
        if (any_eq) begin
          // Close the gap from the first equal entry upward
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (seen[i]) entries_next[i] = entries[i+1];
          end
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_MISS;
        end
      end
      default: ;
    endcase
  end

  // Write back the row and the result
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) entries[i] <= entries_next[i];
      status   <= status_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= dp_cmd.commit;
      if (dp_cmd.commit) count <= count_next;
    end
  end

  assign done        = done_q;
  assign entry_count = count;

endmodule

// File: bench/sorted_list_table_checker.sv
// Checker for the sorted list table core: predicts every result and compares it.
module sorted_list_table_checker
  import slt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              cmd,
  input  logic signed [KEY_W-1:0] key_value,
  input  logic                    done,
  input  logic [1:0]              status,
  input  logic [IDX_W-1:0]        position,
  input  logic [CNT_W-1:0]        entry_count,
  output int                      error_count,
  output int                      pending_count,
  output int                      results_checked,
  output int                      misses_seen,
  output int                      full_seen,
  output int                      peak_fill
);

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] count;
  } outcome_t;

  // Predicted contents: ascending signed keys, valid below fill
  logic signed [KEY_W-1:0] sorted_keys [CAPACITY];
  int                      fill;
  outcome_t                expected_results [$];
  int                      errors;
  int                      checked;
  int                      misses;
  int                      fulls;
  int                      peak;

  // Apply one command to the predicted list and return the result it gives
  function automatic outcome_t apply_command(logic [1:0] op, logic signed [KEY_W-1:0] key);
    outcome_t res;
    int       at;
    res.status   = ST_OK;
    res.position = '0;
    case (op)
      CMD_INSERT: begin
        if (fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // new key goes ahead of the first entry that is not smaller
          at = 0;
          while (at < fill && sorted_keys[at] < key) at++;
          for (int i = fill; i > at; i--) sorted_keys[i] = sorted_keys[i-1];
          sorted_keys[at] = key;
          fill++;
        end
      end
      CMD_SEARCH: begin
        at = 0;
        while (at < fill && sorted_keys[at] != key) at++;
        if (at < fill) res.position = at[IDX_W-1:0];
        else res.status = ST_MISS;
      end
      CMD_REMOVE: begin
        at = 0;
        while (at < fill && sorted_keys[at] != key) at++;
        if (at < fill) begin
          for (int i = at; i + 1 < fill; i++) sorted_keys[i] = sorted_keys[i+1];
          fill--;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        // unused code: leave the list alone
      end
    endcase
    res.count = fill[CNT_W-1:0];
    return res;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Compare results against the oldest prediction, then predict new transfers
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      fill    = 0;
      errors  = 0;
      checked = 0;
      misses  = 0;
      fulls   = 0;
      peak    = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, count", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (position !== want.position)
            report_mismatch("position", int'(position), int'(want.position));
          if (entry_count !== want.count)
            report_mismatch("entry_count", int'(entry_count), int'(want.count));
        end
      end
      if (start && !busy) begin
        want = apply_command(cmd, key_value);
        if (want.status == ST_MISS) misses++;
        if (want.status == ST_FULL) fulls++;
        if (fill > peak) peak = fill;
        expected_results.push_back(want);
      end
    end
    error_count     <= errors;
    pending_count   <= expected_results.size();
    results_checked <= checked;
    misses_seen     <= misses;
    full_seen       <= fulls;
    peak_fill       <= peak;
  end

endmodule

// File: bench/sorted_list_table_core_test.sv
// Top of the sorted list table bench: clock, reset, command stimulus and verdict.
module sorted_list_table_core_test;
  import slt_pkg::*;

  localparam logic [1:0]       CMD_UNUSED     = 2'd3;
  localparam int               WATCHDOG_LIMIT = 1000;
  localparam logic signed [31:0] KEY_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX      = 32'sh7FFF_FFFF;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              cmd = CMD_SEARCH;
  logic signed [KEY_W-1:0] key_value = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic [IDX_W-1:0]        position;
  logic [CNT_W-1:0]        entry_count;

  int error_count;
  int pending_count;
  int results_checked;
  int misses_seen;
  int full_seen;
  int peak_fill;

  // Stimulus-side record of stored keys, used to aim keys and to fill the list
  logic signed [KEY_W-1:0] stored_keys [$];
  bit                      allow_idle = 1'b1;
  int                      commands_sent = 0;
  int                      stall_cycles = 0;

  always #2 clk = ~clk;

  sorted_list_table_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .key_value   (key_value),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  sorted_list_table_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .key_value       (key_value),
    .done            (done),
    .status          (status),
    .position        (position),
    .entry_count     (entry_count),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .misses_seen     (misses_seen),
    .full_seen       (full_seen),
    .peak_fill       (peak_fill)
  );

  // Drive one command and hold it until the core takes the transfer
  task automatic issue(logic [1:0] op, logic signed [KEY_W-1:0] key);
    int idx;
    while (allow_idle && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= op;
    key_value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
    // track contents loosely so later keys hit stored entries
    if (op == CMD_INSERT && stored_keys.size() < CAPACITY) begin
      stored_keys.push_back(key);
    end else if (op == CMD_REMOVE) begin
      idx = 0;
      while (idx < stored_keys.size() && stored_keys[idx] != key) idx++;
      if (idx < stored_keys.size()) stored_keys.delete(idx);
    end
  endtask

  // Pick a key: a stored one with the given chance, else extreme, small or wide
  function automatic logic signed [KEY_W-1:0] pick_key(int stored_pct);
    int r;
    r = $urandom_range(0, 99);
    if (stored_keys.size() > 0 && $urandom_range(0, 99) < stored_pct)
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r < 35) return $signed($urandom_range(0, 15)) - 32'sd8;
    return $signed($urandom);
  endfunction

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    logic [1:0]       op;
    bit               grow;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, extremes, duplicates, unused code, full list
    issue(CMD_SEARCH, 32'sd0);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_INSERT, KEY_MAX);
    issue(CMD_INSERT, KEY_MIN);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_SEARCH, 32'sd0);
    issue(CMD_SEARCH, KEY_MIN);
    issue(CMD_REMOVE, -32'sd1);
    issue(CMD_REMOVE, 32'sd5);
    issue(CMD_UNUSED, 32'sd0);
    while (stored_keys.size() < CAPACITY) issue(CMD_INSERT, $signed($urandom));
    issue(CMD_INSERT, 32'sd1);
    issue(CMD_SEARCH, KEY_MAX);
    issue(CMD_REMOVE, KEY_MIN);

    // Random: alternate growing and draining phases so the list swings full to empty
    for (int n = 0; n < 600; n++) begin
      allow_idle = !(n >= 250 && n < 400);
      grow = ((n / 60) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 4)                 op = CMD_UNUSED;
      else if (r < (grow ? 60 : 24)) op = CMD_INSERT;
      else if (r < (grow ? 80 : 44)) op = CMD_SEARCH;
      else                       op = CMD_REMOVE;
      case (op)
        CMD_INSERT: issue(op, pick_key(40));
        CMD_SEARCH: issue(op, pick_key(60));
        CMD_REMOVE: issue(op, pick_key(80));
        default:    issue(op, $signed($urandom));
      endcase
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for the core's latency
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d commands, checked %0d results (%0d misses, %0d full refusals).",
             commands_sent, results_checked, misses_seen, full_seen);
    $display("List occupancy peaked at %0d entries.", peak_fill);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
